// ===== sv/cpa_pkg.sv =====
// Shared types and constants of the contiguous page allocator.
package cpa_pkg;

  localparam int unsigned PAGE_REACH = 64;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned PAGE_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 2'd1;

  typedef struct packed {
    logic              req_type;
    logic [LEN_W-1:0]  run_length;
    logic [PAGE_W-1:0] free_start;
  } cpa_req_t;

  typedef struct packed {
    logic              status;
    logic [PAGE_W-1:0] start_page;
  } cpa_rsp_t;

  // Control from the sequencer to the hole tracker.
  typedef struct packed {
    logic       clear;
    logic       step;
    logic       is_free;
    logic [1:0] mode;
  } cpa_fit_ctl_t;

  // Chosen run as seen by the sequencer.
  typedef struct packed {
    logic              have;
    logic [PAGE_W-1:0] pick;
  } cpa_fit_res_t;

endpackage

// ===== sv/cpa_cell.sv =====
// One page cell of the circulating free map.
module cpa_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_en_i,
  input  logic shift_in_i,
  output logic free_o
);

  logic free_q;

  // Take the neighbor's bit whenever the ring advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b1;
    end else if (shift_en_i) begin
      free_q <= shift_in_i;
    end
  end

  assign free_o = free_q;

endmodule

// ===== sv/cpa_fit.sv =====
// Hole tracker: follows free runs page by page and keeps the chosen run.
module cpa_fit #(
  parameter int unsigned IW = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cpa_pkg::cpa_fit_ctl_t ctl_i,
  input  logic [IW-1:0]         pos_i,
  input  logic [cpa_pkg::LEN_W-1:0] len_i,
  output cpa_pkg::cpa_fit_res_t res_o
);

  localparam int unsigned WW = IW + 8;

  logic [cpa_pkg::LEN_W-1:0]  hole_q, hole_d, pick_len_q, pick_len_d, hole_inc;
  logic [cpa_pkg::PAGE_W-1:0] pick_q, pick_d;
  logic                       have_q, have_d, take;
  logic [WW-1:0]              first_start, close_start;

  assign hole_inc    = hole_q + cpa_pkg::LEN_W'(1);
  assign first_start = WW'(pos_i) + WW'(1) - WW'(len_i);
  assign close_start = WW'(pos_i) - WW'(hole_q);

  always_comb begin
    if (!have_q) begin
      take = 1'b1;
    end else if (ctl_i.mode == cpa_pkg::FIT_BEST) begin
      take = hole_q < pick_len_q;
    end else begin
      take = hole_q > pick_len_q;
    end
  end

  always_comb begin
    hole_d     = hole_q;
    pick_d     = pick_q;
    pick_len_d = pick_len_q;
    have_d     = have_q;
    if (ctl_i.clear) begin
      hole_d     = '0;
      pick_len_d = '0;
      have_d     = 1'b0;
    end else if (ctl_i.step) begin
      if (ctl_i.is_free) begin
        hole_d = hole_inc;
        // First fit: lock the first run that reaches the length.
        if (ctl_i.mode == cpa_pkg::FIT_FIRST && !have_q && hole_inc == len_i) begin
          have_d = 1'b1;
          pick_d = first_start[cpa_pkg::PAGE_W-1:0];
        end
      end else begin
        if (ctl_i.mode != cpa_pkg::FIT_FIRST && hole_q >= len_i && take) begin
          have_d     = 1'b1;
          pick_len_d = hole_q;
          pick_d     = close_start[cpa_pkg::PAGE_W-1:0];
        end
        hole_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      hole_q     <= '0;
      pick_len_q <= '0;
      pick_q     <= '0;
    end else begin
      have_q     <= have_d;
      hole_q     <= hole_d;
      pick_len_q <= pick_len_d;
      pick_q     <= pick_d;
    end
  end

  assign res_o.have = have_q;
  assign res_o.pick = pick_q;

endmodule

// ===== sv/contiguous_page_allocator_top.sv =====
// Top level of the contiguous page allocator: page ring, sequencer and config registers.
// Steps from the request transfer to the result: a free makes one marking pass of the page
// ring; an allocate that passes the length and mode checks makes a search pass, the close and
// pick steps and a marking pass, or ends after pick when no hole fits; one that fails them makes no pass.
// Throughput is one item at a time, set by the page ring: one page passes the head cell per
// cycle, once for the search and once for marking; busy drops as the result appears.
// Reset: asynchronous, active low; every page free, fit_mode first fit, 64 pages; no stall.
module contiguous_page_allocator_top #(
  parameter int unsigned MAX_PAGES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  cpa_pkg::cpa_req_t                  req_i,
  output logic                               done_o,
  output cpa_pkg::cpa_rsp_t                  rsp_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cpa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Counter over ring positions, and a position wide enough to name the page past the end.
  localparam int unsigned CW  = $clog2(MAX_PAGES);
  localparam int unsigned IW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned WW  = IW + 8;
  localparam int unsigned LIM = (MAX_PAGES < cpa_pkg::PAGE_REACH) ? MAX_PAGES
                                                                  : cpa_pkg::PAGE_REACH;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_PICK,
    ST_MARK
  } state_e;

  state_e                             state_q, state_d;
  logic [CW-1:0]                      cnt_q, cnt_d;
  cpa_pkg::cpa_req_t                  req_q, req_d;
  logic [cpa_pkg::LEN_W-1:0]          n_q, n_d, n_now;
  logic                               done_q, done_d;
  cpa_pkg::cpa_rsp_t                  rsp_q, rsp_d;
  logic [1:0]                         fit_mode_q;
  logic [cpa_pkg::LEN_W-1:0]          pages_q;

  logic [MAX_PAGES-1:0]               cell_free;
  logic                               shift_en, tail_bit, head, mark_bit, in_run, last;
  logic                               accept, fail_now;
  logic [IW-1:0]                      pos;
  logic [WW-1:0]                      pos_w, run_lo, run_hi;
  cpa_pkg::cpa_fit_ctl_t              fit_ctl;
  cpa_pkg::cpa_fit_res_t              fit_res;

  // ---------------------------------------------------------------------------
  // Configuration registers; the user must write them only while idle, which the block does not enforce; always ready.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= cpa_pkg::FIT_FIRST;
      pages_q    <= cpa_pkg::LEN_W'(cpa_pkg::PAGE_REACH);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cpa_pkg::CFG_FIT_MODE:     fit_mode_q <= cfg_data_i[1:0];
        cpa_pkg::CFG_PAGES_IN_USE: pages_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Managed page count: clamp to the ring size and to the reach of start_page.
  assign n_now = (pages_q > cpa_pkg::LEN_W'(LIM)) ? cpa_pkg::LEN_W'(LIM) : pages_q;

  // ---------------------------------------------------------------------------
  // Page ring: page i sits in the head cell at step i of a pass; after a full
  // pass every page is back where it started.
  // ---------------------------------------------------------------------------
  assign shift_en = (state_q == ST_SCAN) || (state_q == ST_MARK);
  assign head     = cell_free[0];
  assign tail_bit = (state_q == ST_MARK) ? mark_bit : head;

  for (genvar k = 0; k < MAX_PAGES; k++) begin : g_cell
    logic shift_in;
    if (k == MAX_PAGES - 1) begin : g_tail
      assign shift_in = tail_bit;
    end else begin : g_mid
      assign shift_in = cell_free[k+1];
    end
    cpa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en),
      .shift_in_i (shift_in),
      .free_o     (cell_free[k])
    );
  end

  // Ring position; the close step stands for the used page just past the end.
  assign pos   = (state_q == ST_CLOSE) ? IW'(MAX_PAGES) : IW'(cnt_q);
  assign pos_w = WW'(pos);
  assign last  = (cnt_q == CW'(MAX_PAGES - 1));

  // Rewrite the head bit on the marking pass: used over the picked run,
  // free over the requested run inside the managed range.
  assign run_lo = (req_q.req_type == cpa_pkg::REQ_ALLOC) ? WW'(fit_res.pick)
                                                         : WW'(req_q.free_start);
  assign run_hi = run_lo + WW'(req_q.run_length);
  assign in_run = (pos_w >= run_lo) && (pos_w < run_hi);

  always_comb begin
    if (req_q.req_type == cpa_pkg::REQ_ALLOC) begin
      mark_bit = in_run ? 1'b0 : head;
    end else begin
      mark_bit = (in_run && pos_w < WW'(n_q)) ? 1'b1 : head;
    end
  end

  // ---------------------------------------------------------------------------
  // Hole tracker
  // ---------------------------------------------------------------------------
  assign accept = start && !busy;

  assign fit_ctl.clear   = accept;
  assign fit_ctl.step    = (state_q == ST_SCAN) || (state_q == ST_CLOSE);
  assign fit_ctl.is_free = (state_q == ST_SCAN) && head && (pos_w < WW'(n_q));
  assign fit_ctl.mode    = fit_mode_q;

  cpa_fit #(
    .IW (IW)
  ) u_fit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fit_ctl),
    .pos_i  (pos),
    .len_i  (req_q.run_length),
    .res_o  (fit_res)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  // Reject an allocate at once when no run can exist or the fit mode is none of the three named.
  assign fail_now = (req_i.run_length == '0) || (req_i.run_length > n_now)
                 || (fit_mode_q != cpa_pkg::FIT_FIRST && fit_mode_q != cpa_pkg::FIT_BEST
                     && fit_mode_q != cpa_pkg::FIT_WORST);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    req_d   = req_q;
    n_d     = n_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          n_d   = n_now;
          cnt_d = '0;
          if (req_i.req_type == cpa_pkg::REQ_FREE) begin
            state_d = ST_MARK;
          end else if (fail_now) begin
            done_d           = 1'b1;
            rsp_d.status     = cpa_pkg::STATUS_NO_SPACE;
            rsp_d.start_page = '0;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (last) begin
          cnt_d   = '0;
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        cnt_d = '0;
        if (fit_res.have) begin
          state_d = ST_MARK;
        end else begin
          state_d          = ST_IDLE;
          done_d           = 1'b1;
          rsp_d.status     = cpa_pkg::STATUS_NO_SPACE;
          rsp_d.start_page = '0;
        end
      end
      ST_MARK: begin
        cnt_d = cnt_q + CW'(1);
        if (last) begin
          cnt_d        = '0;
          state_d      = ST_IDLE;
          done_d       = 1'b1;
          rsp_d.status = cpa_pkg::STATUS_OK;
          rsp_d.start_page = (req_q.req_type == cpa_pkg::REQ_ALLOC) ? fit_res.pick : '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      req_q   <= '0;
      n_q     <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      req_q   <= req_d;
      n_q     <= n_d;
      rsp_q   <= rsp_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== sv/cpa_checker.sv =====
// Port-level checks of the contiguous page allocator, bound to the top level.
module cpa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input cpa_pkg::cpa_req_t req_i,
  input logic              done_o,
  input cpa_pkg::cpa_rsp_t rsp_o
);

  // A result is only shown once the block has gone back to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done_o while busy");

  // A zero length allocate is refused in the next cycle.
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.req_type == cpa_pkg::REQ_ALLOC && req_i.run_length == '0)
    |=> (done_o && rsp_o.status == cpa_pkg::STATUS_NO_SPACE))
    else $error("zero length allocate not refused");

  // Starting a long request never shows a stale result.
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> !done_o)
    else $error("result shown as work starts");

  // A refusal carries page zero.
  a_fail_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == cpa_pkg::STATUS_NO_SPACE) |-> rsp_o.start_page == '0)
    else $error("refusal with nonzero start page");

endmodule

bind contiguous_page_allocator_top cpa_checker u_cpa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ===== tb/contiguous_page_allocator_top_tb.sv =====
// Self-checking testbench for the contiguous page allocator: directed table, then random phases.
module contiguous_page_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpa_pkg::*;

  localparam int unsigned MAX_PAGES    = 64;
  // Longest item: search pass plus marking pass through the page ring.
  localparam int unsigned ITEM_CYCLES  = 2 * MAX_PAGES + 3;
  localparam int unsigned DRAIN_CYCLES = ITEM_CYCLES + 8;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 90;
  localparam int unsigned MAX_GAP      = 40;
  localparam int unsigned SHOWN_ERRORS = 10;

  // Codes the package leaves unnamed: the spare fit mode and the spare register slots.
  localparam logic [1:0]           FIT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT} idle_mode_e;
  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    cpa_req_t              req;
    bit                    has_rsp;
    cpa_rsp_t              rsp;
  } plan_row_t;

  typedef struct {
    int unsigned at;
    int unsigned len;
  } live_run_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  cpa_req_t              req_i       = '0;
  logic                  done_o;
  cpa_rsp_t              rsp_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Shadow of the allocator: page map (1 = free) and the two registers.
  logic [MAX_PAGES-1:0]  page_map;
  logic [1:0]            fit_mode_q;
  logic [CFG_DATA_W-1:0] page_count_q;

  cpa_rsp_t    due_rsp[$];     // responses still owed by the block, oldest first
  live_run_t   live_runs[$];   // runs handed out and not yet returned
  plan_row_t   plan[$];
  idle_mode_e  idle_mode   = IDLE_NONE;
  bit          start_held  = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  contiguous_page_allocator_top #(
    .MAX_PAGES(MAX_PAGES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or drops a response.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= SHOWN_ERRORS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Pages actually managed: the register clipped to the page count and the 6-bit reach.
  function automatic int unsigned managed_pages();
    int unsigned n;
    n = page_count_q;
    if (n > MAX_PAGES) n = MAX_PAGES;
    if (n > PAGE_REACH) n = PAGE_REACH;
    return n;
  endfunction

  // Search the map for a hole of len pages under the current fit mode.
  // The slot just past the managed range counts as used, closing the last hole.
  function automatic bit find_hole(input int unsigned len, output int unsigned at);
    int unsigned n;
    int unsigned hole;
    int unsigned pick_at;
    int unsigned pick_len;
    bit          have;
    bit          take;
    bit          pg_free;
    n        = managed_pages();
    hole     = 0;
    pick_at  = 0;
    pick_len = 0;
    have     = 1'b0;
    at       = 0;
    if (len == 0 || len > n || fit_mode_q > FIT_WORST) return 1'b0;
    for (int unsigned i = 0; i <= n; i++) begin
      pg_free = (i < n) && page_map[i];
      if (pg_free) begin
        hole++;
        if (fit_mode_q == FIT_FIRST && hole == len) begin
          at = i + 1 - len;
          return 1'b1;
        end
      end else begin
        if (hole >= len) begin
          if (!have) take = 1'b1;
          else if (fit_mode_q == FIT_BEST) take = hole < pick_len;
          else take = hole > pick_len;
          if (take) begin
            have     = 1'b1;
            pick_len = hole;
            pick_at  = i - hole;
          end
        end
        hole = 0;
      end
    end
    at = pick_at;
    return have;
  endfunction

  // Apply one request to the shadow map and return the response it earns.
  function automatic cpa_rsp_t serve_request(input cpa_req_t r);
    cpa_rsp_t    rsp;
    int unsigned at;
    int unsigned n;
    rsp.status     = STATUS_OK;
    rsp.start_page = '0;
    n = managed_pages();
    if (r.req_type == REQ_ALLOC) begin
      if (find_hole(r.run_length, at)) begin
        for (int unsigned i = 0; i < r.run_length; i++) page_map[at + i] = 1'b0;
        rsp.start_page = at[PAGE_W-1:0];
      end else begin
        rsp.status = STATUS_NO_SPACE;
      end
    end else begin
      for (int unsigned i = 0; i < r.run_length; i++) begin
        if (r.free_start + i < n) page_map[r.free_start + i] = 1'b1;
      end
    end
    return rsp;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned g;
    int unsigned pct;
    g = 0;
    case (idle_mode)
      IDLE_HEAVY: pct = 88;
      IDLE_LIGHT: pct = 17;
      default:    pct = 0;
    endcase
    while (g < MAX_GAP && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  // Lower start and hold until the block has answered everything and gone idle.
  task automatic drain_all();
    if (start_held) start <= 1'b0;
    start_held = 1'b0;
    while (due_rsp.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Present one request, hold it until the block takes it, then record what it owes.
  task automatic send_req(input cpa_req_t r, input bit has_rsp, input cpa_rsp_t rsp);
    cpa_rsp_t    want;
    int unsigned gap;
    live_run_t   lr;
    req_i <= r;
    if (!start_held) start <= 1'b1;
    start_held = 1'b1;
    do @(posedge clk_i); while (busy);
    // Transfer happened at this edge.
    want = serve_request(r);
    due_rsp.push_back(has_rsp ? rsp : want);
    if (r.req_type == REQ_ALLOC && want.status == STATUS_OK) begin
      lr.at  = want.start_page;
      lr.len = r.run_length;
      live_runs.push_back(lr);
    end
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      start_held = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Registers change only with the block idle and nothing owed.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_all();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FIT_MODE:     fit_mode_q   = val[1:0];
      CFG_PAGES_IN_USE: page_count_q = val;
      default: ;
    endcase
    // Let valid drop before the next write.
    @(posedge clk_i);
  endtask

  function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.kind    = ROW_CFG;
    row.idx     = idx;
    row.data    = val;
    row.req     = '0;
    row.has_rsp = 1'b0;
    row.rsp     = '0;
    plan.push_back(row);
  endfunction

  // A request row; has_rsp marks rows whose response is typed in here.
  function automatic void plan_req(input logic kind, input int unsigned len,
                                   input int unsigned at, input bit has_rsp = 1'b0,
                                   input logic st = STATUS_OK, input int unsigned pg = 0);
    plan_row_t row;
    row.kind           = ROW_REQ;
    row.idx            = '0;
    row.data           = '0;
    row.req.req_type   = kind;
    row.req.run_length = len[LEN_W-1:0];
    row.req.free_start = at[PAGE_W-1:0];
    row.has_rsp        = has_rsp;
    row.rsp.status     = st;
    row.rsp.start_page = pg[PAGE_W-1:0];
    plan.push_back(row);
  endfunction

  // Random request: mostly returns of live runs and short allocations, some noise.
  function automatic cpa_req_t make_random_req();
    cpa_req_t    r;
    int unsigned pick;
    int unsigned k;
    live_run_t   lr;
    r.req_type   = REQ_ALLOC;
    r.free_start = PAGE_W'($urandom);
    r.run_length = LEN_W'($urandom_range(1, 8));
    pick = $urandom_range(99);
    if (pick < 35 && live_runs.size() != 0) begin
      k  = $urandom_range(live_runs.size() - 1);
      lr = live_runs[k];
      live_runs.delete(k);
      r.req_type   = REQ_FREE;
      r.free_start = lr.at[PAGE_W-1:0];
      r.run_length = lr.len[LEN_W-1:0];
    end else if (pick < 50) begin
      r.req_type   = REQ_FREE;
      r.run_length = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(16));
    end else begin
      pick = $urandom_range(99);
      if (pick >= 95)      r.run_length = LEN_W'($urandom_range(65, 127));
      else if (pick >= 90) r.run_length = '0;
      else if (pick >= 70) r.run_length = LEN_W'($urandom_range(1, MAX_PAGES));
    end
    return r;
  endfunction

  // Check every response against the oldest one owed.
  always @(posedge clk_i) begin
    cpa_rsp_t want;
    if (rst_ni && done_o) begin
      if (due_rsp.size() == 0) begin
        flag_error($sformatf("response with none owed: status %0d start_page %0d",
                             rsp_o.status, rsp_o.start_page));
      end else begin
        want = due_rsp.pop_front();
        if (rsp_o.status !== want.status)
          flag_error($sformatf("status expected %0d got %0d", want.status, rsp_o.status));
        if (rsp_o.start_page !== want.start_page)
          flag_error($sformatf("start_page expected %0d got %0d",
                               want.start_page, rsp_o.start_page));
      end
    end
  end

  initial begin
    cpa_rsp_t    none;
    cpa_req_t    r;
    logic [1:0]  mode;
    int unsigned pick;
    logic [CFG_DATA_W-1:0] count;

    none         = '0;
    page_map     = '1;
    fit_mode_q   = FIT_FIRST;
    page_count_q = CFG_DATA_W'(PAGE_REACH);

    // Directed table. Map after reset: every page free, first fit, 64 pages.
    plan_req(REQ_ALLOC, 0, 0, 1, STATUS_NO_SPACE, 0);    // zero length
    plan_req(REQ_ALLOC, 65, 63, 1, STATUS_NO_SPACE, 0);  // longer than the range
    plan_req(REQ_ALLOC, 127, 0, 1, STATUS_NO_SPACE, 0);
    plan_req(REQ_ALLOC, 1, 0, 1, STATUS_OK, 0);
    plan_req(REQ_ALLOC, 64, 0, 1, STATUS_NO_SPACE, 0);   // one page short
    plan_req(REQ_FREE, 1, 0, 1, STATUS_OK, 0);
    plan_req(REQ_ALLOC, 64, 0, 1, STATUS_OK, 0);         // whole range
    plan_req(REQ_ALLOC, 1, 0, 1, STATUS_NO_SPACE, 0);    // map full
    plan_req(REQ_FREE, 127, 63, 1, STATUS_OK, 0);        // run past the top: only page 63
    plan_req(REQ_ALLOC, 1, 0, 1, STATUS_OK, 63);
    plan_req(REQ_FREE, 64, 0, 1, STATUS_OK, 0);
    plan_req(REQ_FREE, 0, 5, 1, STATUS_OK, 0);           // zero length free
    // Carve holes of 3, 5 and 42 pages, then place by each rule.
    plan_req(REQ_ALLOC, 10, 0);
    plan_req(REQ_FREE, 3, 2);
    plan_req(REQ_ALLOC, 12, 0);
    plan_req(REQ_FREE, 5, 14);
    plan_cfg(CFG_FIT_MODE, FIT_BEST);
    plan_req(REQ_ALLOC, 4, 0);
    plan_req(REQ_ALLOC, 2, 0);
    plan_cfg(CFG_FIT_MODE, FIT_WORST);
    plan_req(REQ_ALLOC, 3, 0);
    plan_cfg(CFG_FIT_MODE, FIT_UNUSED);
    plan_req(REQ_ALLOC, 1, 0, 1, STATUS_NO_SPACE, 0);    // spare mode finds nothing
    plan_cfg(CFG_FIT_MODE, FIT_FIRST);
    plan_cfg(CFG_PAGES_IN_USE, 1);
    plan_req(REQ_ALLOC, 1, 0);
    plan_req(REQ_FREE, 64, 0);
    plan_req(REQ_ALLOC, 1, 0);
    plan_cfg(CFG_PAGES_IN_USE, 0);
    plan_req(REQ_ALLOC, 1, 0, 1, STATUS_NO_SPACE, 0);    // nothing managed
    plan_cfg(CFG_PAGES_IN_USE, 127);                      // clipped to the full range
    plan_cfg(CFG_SPARE2, 127);
    plan_cfg(CFG_SPARE3, 0);
    plan_req(REQ_ALLOC, 64, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].data);
      else send_req(plan[i].req, plan[i].has_rsp, plan[i].rsp);
    end

    // Random phases: new settings and a new idle pattern per phase.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      if (ph % 4 != 3)       mode = ph % 4;
      else if (ph == PHASES - 1) mode = FIT_UNUSED;
      else                   mode = $urandom_range(2);
      pick = $urandom_range(99);
      if (pick < 60)      count = CFG_DATA_W'(PAGE_REACH);
      else if (pick < 90) count = CFG_DATA_W'($urandom_range(1, PAGE_REACH));
      else if (pick < 95) count = '0;
      else                count = CFG_DATA_W'($urandom_range(65, 127));
      write_reg(CFG_FIT_MODE, mode);
      write_reg(CFG_PAGES_IN_USE, count);
      idle_mode = idle_mode_e'(ph / 4);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        r = make_random_req();
        send_req(r, 1'b0, none);
        // Now and then let the block run dry before the next request.
        if ($urandom_range(49) == 0) drain_all();
      end
    end

    drain_all();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && due_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cpa_pkg.sv
sv/cpa_cell.sv
sv/cpa_fit.sv
sv/contiguous_page_allocator_top.sv
sv/cpa_checker.sv
tb/contiguous_page_allocator_top_tb.sv
